/* design/pcci_pkg.sv */
// ----------------------------------------------------------------------------
// pcci_pkg
// Shared types, constants and the indicator state update for the
// polyphonic clipper with clip indicators.
// ----------------------------------------------------------------------------
`default_nettype none

package pcci_pkg;

    // Default channel count of the state memory
    localparam int CHANNELS_DEF = 16;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 15;
    localparam int KNOB_W   = 14;
    localparam int TIMER_W  = 17;
    localparam int COUNT_W  = 5;
    localparam int CH_W     = 4;
    localparam int IND_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Saturation limits, 1 LSB = 1/1024 V
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'd20480;
    localparam logic [KNOB_W-1:0]  KNOB_MAX  = 14'd10240;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KNOB      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOGIC_MON = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B_COUNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LVL_COUNT = 3'd5;

    // Register reset values
    localparam logic [KNOB_W-1:0]  KNOB_RST = 14'd5120;
    localparam logic [TIMER_W-1:0] HOLD_RST = 17'd4800;

    // Indicator machine modes
    localparam logic [1:0] MODE_LOW_IDLE   = 2'd0;
    localparam logic [1:0] MODE_LOW_TIMER  = 2'd1;
    localparam logic [1:0] MODE_HIGH_IDLE  = 2'd2;
    localparam logic [1:0] MODE_HIGH_TIMER = 2'd3;

    // Indicator codes
    localparam logic [IND_W-1:0] IND_OFF  = 2'd0;
    localparam logic [IND_W-1:0] IND_NORM = 2'd1;
    localparam logic [IND_W-1:0] IND_CLIP = 2'd2;

    // One indicator machine
    typedef struct packed {
        logic [1:0]         mode;
        logic [TIMER_W-1:0] timer;
    } t_chan_st;

    // One memory entry: both ports of one channel
    typedef struct packed {
        t_chan_st a;
        t_chan_st b;
    } t_ent;

    // Control flags of the item in the state stage
    typedef struct packed {
        logic vld;
        logic a_on;
        logic b_on;
        logic a_hit;
        logic b_hit;
    } t_ctl;

    // Advance one indicator machine by one sample
    function automatic t_chan_st f_advance(t_chan_st cur, logic hit,
                                           logic [TIMER_W-1:0] hold, logic lmon);
        t_chan_st nxt;
        nxt = cur;
        case (cur.mode)
            MODE_LOW_TIMER: begin
                if (cur.timer == '0) nxt.mode = MODE_LOW_IDLE;
                else nxt.timer = cur.timer - TIMER_W'(1);
            end
            MODE_LOW_IDLE: begin
                if (hit) begin
                    nxt.mode  = MODE_HIGH_TIMER;
                    nxt.timer = hold;
                end
            end
            MODE_HIGH_TIMER: begin
                if (!lmon && hit) nxt.timer = hold;
                else if (cur.timer == '0) nxt.mode = MODE_HIGH_IDLE;
                else nxt.timer = cur.timer - TIMER_W'(1);
            end
            default: begin
                // high idle: drop to the low timer once clipping stops
                if (!hit) begin
                    nxt.mode  = MODE_LOW_TIMER;
                    nxt.timer = hold;
                end
            end
        endcase
        return nxt;
    endfunction

    // Light code for a mode
    function automatic logic [IND_W-1:0] f_ind(logic [1:0] mode);
        return mode[1] ? IND_CLIP : IND_NORM;
    endfunction

endpackage

`default_nettype wire

/* design/poly_clipper_with_clip_indicator.sv */
// ----------------------------------------------------------------------------
// poly_clipper_with_clip_indicator
// Polyphonic hard clipper: clips ports A and B of one channel per item to
// the selected clip level and runs a hold-timed clip light per port and
// channel.
//
//   channel   dir  handshake                 payload
//   input     in   i_in_valid / o_in_stall   i_channel, i_a_sample,
//                                            i_b_sample, i_level_sample
//   output    out  o_out_valid / i_out_stall o_a_out, o_b_out,
//                                            o_a_indicator, o_b_indicator
//   config    in   i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while the output does not stall; each item is
// clipped at accept, then goes through the state read-modify-write stage and
// the result register. The rate is set by the state memory: one read at
// accept and one write when the item leaves the state stage, with
// same-channel forwarding. Reset clears the entry valid bits; there is no
// clearing pass. A stall on the output holds the result register, then the
// state stage, then the input.
// ----------------------------------------------------------------------------
`default_nettype none

module poly_clipper_with_clip_indicator
    import pcci_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data,
    // input items
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [CH_W-1:0]            i_channel,
    input  wire logic signed [SAMPLE_W-1:0] i_a_sample,
    input  wire logic signed [SAMPLE_W-1:0] i_b_sample,
    input  wire logic signed [SAMPLE_W-1:0] i_level_sample,
    // result items
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0]      o_a_out,
    output logic signed [SAMPLE_W-1:0]      o_b_out,
    output logic [IND_W-1:0]                o_a_indicator,
    output logic [IND_W-1:0]                o_b_indicator
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EXT_W = 7;

    // Configuration registers
    logic [KNOB_W-1:0]   r_knob;
    logic [TIMER_W-1:0]  r_hold;
    logic                r_lmon;
    logic [COUNT_W-1:0]  r_a_count;
    logic [COUNT_W-1:0]  r_b_count;
    logic [COUNT_W-1:0]  r_lvl_count;

    // Pipeline
    logic                       accept;
    logic                       s1_go;
    logic                       out_take;
    logic [EXT_W-1:0]           ch_ext;
    logic [IDX_W-1:0]           in_addr;
    logic                       in_range;
    logic signed [SAMPLE_W-1:0] a_clip;
    logic signed [SAMPLE_W-1:0] b_clip;
    logic                       a_hit;
    logic                       b_hit;
    t_ctl                       r_s1_ctl;
    logic [IDX_W-1:0]           r_s1_addr;
    logic signed [SAMPLE_W-1:0] r_s1_a;
    logic signed [SAMPLE_W-1:0] r_s1_b;
    logic [IND_W-1:0]           a_ind;
    logic [IND_W-1:0]           b_ind;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knob      <= KNOB_RST;
            r_hold      <= HOLD_RST;
            r_lmon      <= 1'b0;
            r_a_count   <= '0;
            r_b_count   <= '0;
            r_lvl_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KNOB:      r_knob      <= i_cfg_data[KNOB_W-1:0];
                REG_HOLD:      r_hold      <= i_cfg_data[TIMER_W-1:0];
                REG_LOGIC_MON: r_lmon      <= i_cfg_data[0];
                REG_A_COUNT:   r_a_count   <= i_cfg_data[COUNT_W-1:0];
                REG_B_COUNT:   r_b_count   <= i_cfg_data[COUNT_W-1:0];
                REG_LVL_COUNT: r_lvl_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake
    assign out_take   = o_out_valid && !i_out_stall;
    assign s1_go      = r_s1_ctl.vld && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_ctl.vld && !s1_go;
    assign accept     = i_in_valid && !o_in_stall;

    // Channel address and range
    assign ch_ext   = EXT_W'(i_channel);
    assign in_addr  = ch_ext[IDX_W-1:0];
    assign in_range = (ch_ext < EXT_W'(CHANNELS));

    pcci_clip u_clip (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_channel      (i_channel),
        .i_a_sample     (i_a_sample),
        .i_b_sample     (i_b_sample),
        .i_level_sample (i_level_sample),
        .i_knob         (r_knob),
        .i_level_count  (r_lvl_count),
        .o_a_clip       (a_clip),
        .o_b_clip       (b_clip),
        .o_a_hit        (a_hit),
        .o_b_hit        (b_hit)
    );

    // Advance the item into the state stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (accept) begin
            r_s1_ctl.vld   <= 1'b1;
            r_s1_ctl.a_on  <= in_range && ({1'b0, i_channel} < r_a_count);
            r_s1_ctl.b_on  <= in_range && ({1'b0, i_channel} < r_b_count);
            r_s1_ctl.a_hit <= a_hit;
            r_s1_ctl.b_hit <= b_hit;
        end else if (s1_go) begin
            r_s1_ctl.vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr <= in_addr;
            r_s1_a    <= a_clip;
            r_s1_b    <= b_clip;
        end
    end

    pcci_state #(
        .CHANNELS (CHANNELS)
    ) u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (in_addr),
        .i_ctl     (r_s1_ctl),
        .i_addr    (r_s1_addr),
        .i_go      (s1_go),
        .i_hold    (r_hold),
        .i_lmon    (r_lmon),
        .o_a_ind   (a_ind),
        .o_b_ind   (b_ind)
    );

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (s1_go) begin
            o_out_valid <= 1'b1;
        end else if (out_take) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            o_a_out       <= r_s1_ctl.a_on ? r_s1_a : '0;
            o_b_out       <= r_s1_ctl.b_on ? r_s1_b : '0;
            o_a_indicator <= r_s1_ctl.a_on ? a_ind : IND_OFF;
            o_b_indicator <= r_s1_ctl.b_on ? b_ind : IND_OFF;
        end
    end

endmodule

`default_nettype wire

/* design/pcci_clip.sv */
// ----------------------------------------------------------------------------
// pcci_clip
// Clip level selection with the last-level register, and the symmetric
// hard clip of both ports against that level.
// ----------------------------------------------------------------------------
`default_nettype none

module pcci_clip
    import pcci_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [CH_W-1:0]            i_channel,
    input  wire logic signed [SAMPLE_W-1:0] i_a_sample,
    input  wire logic signed [SAMPLE_W-1:0] i_b_sample,
    input  wire logic signed [SAMPLE_W-1:0] i_level_sample,
    input  wire logic [KNOB_W-1:0]          i_knob,
    input  wire logic [COUNT_W-1:0]         i_level_count,
    output logic signed [SAMPLE_W-1:0]      o_a_clip,
    output logic signed [SAMPLE_W-1:0]      o_b_clip,
    output logic                            o_a_hit,
    output logic                            o_b_hit
);

    logic [LEVEL_W-1:0]      r_last_level;
    logic [LEVEL_W-1:0]      n_last_level;
    logic [SAMPLE_W:0]       lvl_mag;
    logic [LEVEL_W-1:0]      lvl_sat;
    logic [LEVEL_W-1:0]      knob_sat;
    logic [LEVEL_W-1:0]      level;
    logic                    lvl_chan;
    logic signed [SAMPLE_W:0] pos_lim;
    logic signed [SAMPLE_W:0] neg_lim;
    logic signed [SAMPLE_W:0] a_ext;
    logic signed [SAMPLE_W:0] b_ext;

    // Magnitude of the level sample, saturated at 20 V
    assign lvl_mag = i_level_sample[SAMPLE_W-1]
                   ? (SAMPLE_W+1)'(-$signed({i_level_sample[SAMPLE_W-1], i_level_sample}))
                   : (SAMPLE_W+1)'({1'b0, i_level_sample});
    assign lvl_sat = (lvl_mag > (SAMPLE_W+1)'(LEVEL_MAX)) ? LEVEL_MAX
                                                          : lvl_mag[LEVEL_W-1:0];
    assign knob_sat = (i_knob > KNOB_MAX) ? LEVEL_W'(KNOB_MAX) : LEVEL_W'(i_knob);
    assign lvl_chan = ({1'b0, i_channel} < i_level_count);

    // Select the level for this item
    always_comb begin
        n_last_level = r_last_level;
        if (i_level_count == '0) begin
            level = knob_sat;
        end else if (lvl_chan) begin
            level        = lvl_sat;
            n_last_level = lvl_sat;
        end else begin
            level = r_last_level;
        end
    end

    // Hold the level of the latest level channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= '0;
        end else if (i_accept) begin
            r_last_level <= n_last_level;
        end
    end

    // Clip both ports to +/- level
    assign pos_lim = $signed({2'b00, level});
    assign neg_lim = -pos_lim;
    assign a_ext   = {i_a_sample[SAMPLE_W-1], i_a_sample};
    assign b_ext   = {i_b_sample[SAMPLE_W-1], i_b_sample};

    always_comb begin
        o_a_hit  = 1'b1;
        o_a_clip = SAMPLE_W'(pos_lim);
        if (a_ext < neg_lim) begin
            o_a_clip = SAMPLE_W'(neg_lim);
        end else if (a_ext <= pos_lim) begin
            o_a_hit  = 1'b0;
            o_a_clip = i_a_sample;
        end
    end

    always_comb begin
        o_b_hit  = 1'b1;
        o_b_clip = SAMPLE_W'(pos_lim);
        if (b_ext < neg_lim) begin
            o_b_clip = SAMPLE_W'(neg_lim);
        end else if (b_ext <= pos_lim) begin
            o_b_hit  = 1'b0;
            o_b_clip = i_b_sample;
        end
    end

endmodule

`default_nettype wire

/* design/pcci_state.sv */
// ----------------------------------------------------------------------------
// pcci_state
// Per-channel indicator state memory: registered read at accept,
// update in the following stage, write back when the item moves on.
// Forwards the write data when the next item reads the same channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pcci_state
    import pcci_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_rd_en,
    input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_rd_addr,
    input  wire t_ctl                    i_ctl,
    input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_addr,
    input  wire logic                    i_go,
    input  wire logic [TIMER_W-1:0]      i_hold,
    input  wire logic                    i_lmon,
    output logic [IND_W-1:0]             o_a_ind,
    output logic [IND_W-1:0]             o_b_ind
);

    t_ent              r_mem [CHANNELS];
    t_ent              r_q;
    t_ent              r_fwd_data;
    logic              r_fwd;
    logic              r_rvld;
    logic [CHANNELS-1:0] r_vld;
    t_ent              cur;
    t_ent              wdata;
    logic              wr_en;

    // Pick the current entry: forwarded, stored, or reset value
    always_comb begin
        if (r_fwd) cur = r_fwd_data;
        else if (r_rvld) cur = r_q;
        else cur = '0;
    end

    // Advance the machines of the active ports
    always_comb begin
        wdata = cur;
        if (i_ctl.a_on) wdata.a = f_advance(cur.a, i_ctl.a_hit, i_hold, i_lmon);
        if (i_ctl.b_on) wdata.b = f_advance(cur.b, i_ctl.b_hit, i_hold, i_lmon);
    end

    assign wr_en   = i_ctl.vld && i_go && (i_ctl.a_on || i_ctl.b_on);
    assign o_a_ind = f_ind(wdata.a.mode);
    assign o_b_ind = f_ind(wdata.b.mode);

    // State memory
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[i_addr] <= wdata;
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd_data <= wdata;
        end
    end

    // Entry valid bits and forward flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_fwd  <= 1'b0;
            r_rvld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_fwd  <= wr_en && (i_addr == i_rd_addr);
                r_rvld <= r_vld[i_rd_addr];
            end
            if (wr_en) r_vld[i_addr] <= 1'b1;
        end
    end

`ifndef SYNTHESIS
    // Valid bits come out of reset cleared
    a_vld_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (r_vld == '0))
        else $error("valid bits not cleared after reset");

    // A written entry is valid afterwards
    a_vld_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_vld[$past(i_addr)])
        else $error("written entry not marked valid");

    // A read of the entry being written takes the forwarded data
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd_en && wr_en && (i_rd_addr == i_addr)) |=> r_fwd)
        else $error("missing forward on same-channel read");

    // Idle modes always carry a zero timer
    a_idle_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && (wdata.a.mode == MODE_LOW_IDLE || wdata.a.mode == MODE_HIGH_IDLE))
        |-> (wdata.a.timer == '0))
        else $error("port A idle mode with running timer");

    a_idle_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && (wdata.b.mode == MODE_LOW_IDLE || wdata.b.mode == MODE_HIGH_IDLE))
        |-> (wdata.b.timer == '0))
        else $error("port B idle mode with running timer");
`endif

endmodule

`default_nettype wire

/* dv/tb_poly_clipper_with_clip_indicator.sv */
// ----------------------------------------------------------------------------
// tb_poly_clipper_with_clip_indicator
// Self-checking bench for the polyphonic clipper: a queue-fed driver sends
// channel items in bursts, a shadow predictor tracks clip levels and the
// per-channel light machines, and a monitor compares every result in order
// while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------

module tb_poly_clipper_with_clip_indicator;
    import pcci_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
        logic signed [SAMPLE_W-1:0] lvl;
    } clip_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] a_out;
        logic signed [SAMPLE_W-1:0] b_out;
        logic [IND_W-1:0]           a_ind;
        logic [IND_W-1:0]           b_ind;
    } clip_result_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [TIMER_W-1:0] tmr;
    } light_t;

    // Clock, reset and block ports
    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx      = REG_KNOB;
    logic [CFG_DATA_W-1:0]      i_cfg_data     = '0;
    logic                       i_in_valid     = 1'b0;
    logic [CH_W-1:0]            i_channel      = '0;
    logic signed [SAMPLE_W-1:0] i_a_sample     = '0;
    logic signed [SAMPLE_W-1:0] i_b_sample     = '0;
    logic signed [SAMPLE_W-1:0] i_level_sample = '0;
    logic                       i_out_stall    = 1'b0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic signed [SAMPLE_W-1:0] o_a_out;
    logic signed [SAMPLE_W-1:0] o_b_out;
    logic [IND_W-1:0]           o_a_indicator;
    logic [IND_W-1:0]           o_b_indicator;

    // Shadow registers and state
    logic [KNOB_W-1:0]  knob_r    = KNOB_RST;
    logic [TIMER_W-1:0] hold_r    = HOLD_RST;
    logic               lmon_r    = 1'b0;
    logic [COUNT_W-1:0] a_cnt_r   = '0;
    logic [COUNT_W-1:0] b_cnt_r   = '0;
    logic [COUNT_W-1:0] lvl_cnt_r = '0;
    logic [LEVEL_W-1:0] last_lvl  = '0;
    light_t             a_light [CHANNELS_DEF];
    light_t             b_light [CHANNELS_DEF];

    // Stimulus shaping: per-channel overdrive flags that persist across frames
    logic               a_hot [CHANNELS_DEF];
    logic               b_hot [CHANNELS_DEF];

    clip_item_t   pending_q [$];
    clip_result_t clip_expect_q [$];
    int           in_flight = 0;
    int           err_count = 0;

    // Sender and receiver pacing
    clip_item_t drv_item;
    int         burst_left = 4;
    int         gap_left   = 0;
    int         stall_mode = 0;
    int         stall_left = 20;

    poly_clipper_with_clip_indicator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_channel      (i_channel),
        .i_a_sample     (i_a_sample),
        .i_b_sample     (i_b_sample),
        .i_level_sample (i_level_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_a_out        (o_a_out),
        .o_b_out        (o_b_out),
        .o_a_indicator  (o_a_indicator),
        .o_b_indicator  (o_b_indicator)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < CHANNELS_DEF; i++) begin
            a_light[i] = '{mode: MODE_LOW_IDLE, tmr: '0};
            b_light[i] = '{mode: MODE_LOW_IDLE, tmr: '0};
            a_hot[i]   = 1'b0;
            b_hot[i]   = 1'b0;
        end
    end

    // Clip one sample symmetrically and flag whether it was limited
    function automatic logic signed [SAMPLE_W-1:0] clip_to(int v, int lim, output logic hit);
        hit = 1'b1;
        if (v > lim) return SAMPLE_W'(lim);
        if (v < -lim) return SAMPLE_W'(-lim);
        hit = 1'b0;
        return SAMPLE_W'(v);
    endfunction

    // Advance one light machine by one sample
    function automatic light_t step_light(light_t cur, logic hit);
        light_t nxt;
        nxt = cur;
        case (cur.mode)
            MODE_LOW_TIMER: begin
                if (cur.tmr == '0) nxt.mode = MODE_LOW_IDLE;
                else nxt.tmr = cur.tmr - 1'b1;
            end
            MODE_LOW_IDLE: begin
                if (hit) begin
                    nxt.mode = MODE_HIGH_TIMER;
                    nxt.tmr  = hold_r;
                end
            end
            MODE_HIGH_TIMER: begin
                // continued clipping re-arms the on time unless monitoring logic
                if (!lmon_r && hit) nxt.tmr = hold_r;
                else if (cur.tmr == '0) nxt.mode = MODE_HIGH_IDLE;
                else nxt.tmr = cur.tmr - 1'b1;
            end
            default: begin
                if (!hit) begin
                    nxt.mode = MODE_LOW_TIMER;
                    nxt.tmr  = hold_r;
                end
            end
        endcase
        return nxt;
    endfunction

    function automatic logic [IND_W-1:0] light_code(light_t l);
        return (l.mode == MODE_HIGH_IDLE || l.mode == MODE_HIGH_TIMER) ? IND_CLIP : IND_NORM;
    endfunction

    // Work out the clipped outputs and lights for one accepted item
    function automatic clip_result_t predict_clip(clip_item_t it);
        clip_result_t r;
        int           lim;
        int           mag;
        logic         hit;
        r = '0;
        if (lvl_cnt_r == '0) begin
            lim = (knob_r > KNOB_MAX) ? int'(KNOB_MAX) : int'(knob_r);
        end else begin
            if (it.ch < lvl_cnt_r) begin
                mag = int'($signed(it.lvl));
                if (mag < 0) mag = -mag;
                last_lvl = (mag > int'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(mag);
            end
            lim = int'(last_lvl);
        end
        // a 4-bit channel is always inside the state memory
        if (it.ch < a_cnt_r) begin
            r.a_out = clip_to(int'($signed(it.a)), lim, hit);
            a_light[it.ch] = step_light(a_light[it.ch], hit);
            r.a_ind = light_code(a_light[it.ch]);
        end
        if (it.ch < b_cnt_r) begin
            r.b_out = clip_to(int'($signed(it.b)), lim, hit);
            b_light[it.ch] = step_light(b_light[it.ch], hit);
            r.b_ind = light_code(b_light[it.ch]);
        end
        return r;
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("%0t: %s", $time, msg);
    endtask

    function automatic void push_item(int ch, logic signed [SAMPLE_W-1:0] a,
                                      logic signed [SAMPLE_W-1:0] b,
                                      logic signed [SAMPLE_W-1:0] lvl);
        clip_item_t it;
        it.ch  = CH_W'(ch);
        it.a   = a;
        it.b   = b;
        it.lvl = lvl;
        pending_q.push_back(it);
        in_flight++;
    endfunction

    // Pick a sample inside or beyond the expected clip level
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(logic hot, int lim);
        int m;
        case ($urandom_range(0, 9))
            0: return SAMPLE_W'($urandom);
            1: m = hot ? lim + 1 : lim;
            2: if (hot) return 16'sh8000;
               else m = $urandom_range(0, lim);
            default: m = hot ? $urandom_range(lim + 1, 32767) : $urandom_range(0, lim);
        endcase
        return $urandom_range(0, 1) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
    endfunction

    // Write one register; the enable stays high for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                             input int unsigned mask, input bit noisy);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'((value & mask) | (noisy ? ($urandom & ~mask) : 0));
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_KNOB:      knob_r    = data[KNOB_W-1:0];
            REG_HOLD:      hold_r    = data[TIMER_W-1:0];
            REG_LOGIC_MON: lmon_r    = data[0];
            REG_A_COUNT:   a_cnt_r   = data[COUNT_W-1:0];
            REG_B_COUNT:   b_cnt_r   = data[COUNT_W-1:0];
            REG_LVL_COUNT: lvl_cnt_r = data[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int unsigned knob, input int unsigned hold,
                             input int unsigned lmon, input int unsigned a_cnt,
                             input int unsigned b_cnt, input int unsigned l_cnt,
                             input bit noisy);
        write_reg(REG_KNOB, knob, 32'h3FFF, noisy);
        write_reg(REG_HOLD, hold, 32'h1FFFF, noisy);
        write_reg(REG_LOGIC_MON, lmon, 32'h1, noisy);
        write_reg(REG_A_COUNT, a_cnt, 32'h1F, noisy);
        write_reg(REG_B_COUNT, b_cnt, 32'h1F, noisy);
        write_reg(REG_LVL_COUNT, l_cnt, 32'h1F, noisy);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold until every queued item has produced its checked result
    task automatic wait_drained();
        do @(posedge i_clk); while (in_flight != 0);
    endtask

    // Mostly ordered frames with random content, with stray items mixed in
    task automatic gen_phase(input int n_items);
        int left;
        int len;
        int lvl_mag;
        int eff;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(0, 7) == 0) begin
                push_item($urandom_range(0, 15), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                          SAMPLE_W'($urandom));
                left--;
            end else begin
                case ($urandom_range(0, 5))
                    0:       lvl_mag = 0;
                    1:       lvl_mag = 20480;
                    2:       lvl_mag = $urandom_range(20481, 32767);
                    default: lvl_mag = $urandom_range(0, 20480);
                endcase
                if (lvl_cnt_r == '0) eff = (knob_r > KNOB_MAX) ? int'(KNOB_MAX) : int'(knob_r);
                else eff = (lvl_mag > 20480) ? 20480 : lvl_mag;
                len = $urandom_range(1, 16);
                for (int c = 0; c < len && left > 0; c++) begin
                    if ($urandom_range(0, 2) == 0) a_hot[c] = !a_hot[c];
                    if ($urandom_range(0, 2) == 0) b_hot[c] = !b_hot[c];
                    push_item(c, pick_sample(a_hot[c], eff), pick_sample(b_hot[c], eff),
                              $urandom_range(0, 1) ? SAMPLE_W'(-lvl_mag) : SAMPLE_W'(lvl_mag));
                    left--;
                end
            end
        end
    endtask

    // Driver: send queued items in bursts separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) clip_expect_q.push_back(predict_clip(drv_item));
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    drv_item = pending_q.pop_front();
                    i_channel      <= drv_item.ch;
                    i_a_sample     <= drv_item.a;
                    i_b_sample     <= drv_item.b;
                    i_level_sample <= drv_item.lvl;
                    i_in_valid     <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: free, random, heavy or one long stall per stretch
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 40);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 1) == 1);
            2:       i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (stall_left > 2);
        endcase
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        clip_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (clip_expect_q.size() == 0) begin
                note_error("result with no item pending");
            end else begin
                want = clip_expect_q.pop_front();
                in_flight--;
                if (o_a_out !== want.a_out || o_b_out !== want.b_out ||
                    o_a_indicator !== want.a_ind || o_b_indicator !== want.b_ind) begin
                    note_error($sformatf({"mismatch: want a=%0d b=%0d ai=%0d bi=%0d, ",
                                          "got a=%0d b=%0d ai=%0d bi=%0d"},
                                         want.a_out, want.b_out, want.a_ind, want.b_ind,
                                         o_a_out, o_b_out, o_a_indicator, o_b_indicator));
                end
            end
        end
    end

    // Main sequence: reset, directed phases, random phases, final check
    initial begin
        int unsigned knob_v;
        int unsigned hold_v;
        int unsigned lmon_v;
        int unsigned a_v;
        int unsigned b_v;
        int unsigned l_v;
        bit          noisy;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: no active channel, outputs and lights off
        push_item(0, 16'sh7FFF, 16'sh8000, 16'sh8000);
        push_item(15, -16'sd1, 16'sd1, 16'sd0);
        push_item(7, 16'sd0, 16'sd0, 16'sh7FFF);
        wait_drained();

        // Knob above its limit, short hold, B one channel short of A
        configure(16383, 2, 0, 16, 15, 0, 1'b0);
        push_item(0, 16'sh7FFF, 16'sh8000, 16'sd0);
        push_item(0, 16'sd10240, -16'sd10240, 16'sd0);
        push_item(0, 16'sd10241, -16'sd10241, 16'sd0);
        push_item(0, 16'sd0, 16'sd0, 16'sd0);
        push_item(0, 16'sd0, 16'sd0, 16'sd0);
        push_item(0, 16'sd0, 16'sd0, 16'sd0);
        push_item(0, 16'sd0, 16'sd0, 16'sd0);
        push_item(0, 16'sd0, 16'sd0, 16'sd0);
        push_item(15, 16'sd5, 16'sh8000, 16'sd0);
        wait_drained();

        // Level input with two channels, logic monitor on; channel ahead of its level
        configure(0, 2, 1, 4, 4, 2, 1'b0);
        push_item(3, 16'sd100, -16'sd100, 16'sd5);
        push_item(0, 16'sd20480, -16'sd20481, 16'sh8000);
        push_item(1, 16'sd1, -16'sd1, 16'sd0);
        push_item(1, 16'sd0, 16'sd0, 16'sd1);
        push_item(2, 16'sd2, -16'sd2, 16'sd9999);
        push_item(3, 16'sh7FFF, 16'sh8000, 16'sd0);
        push_item(0, -16'sd5, 16'sd5, 16'sh7FFF);
        push_item(1, 16'sd9, 16'sd9, 16'sd1);
        push_item(1, 16'sd9, 16'sd9, 16'sd1);
        push_item(1, 16'sd9, 16'sd9, 16'sd1);
        push_item(1, 16'sd9, 16'sd9, 16'sd1);
        wait_drained();

        // Random phases; the long holds come last so the lights do not stay latched
        for (int p = 0; p < 8; p++) begin
            knob_v = ($urandom_range(0, 3) == 0) ? $urandom_range(10241, 16383)
                                                 : $urandom_range(0, 10240);
            hold_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 5);
            lmon_v = $urandom_range(0, 1);
            a_v    = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(2, 16);
            b_v    = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(2, 16);
            l_v    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            noisy  = ($urandom_range(0, 1) == 1);
            case (p)
                0: begin knob_v = 0; hold_v = 0; lmon_v = 0; a_v = 16; b_v = 16; l_v = 0; end
                1: begin knob_v = 16383; hold_v = 1; lmon_v = 1; a_v = 16; b_v = 16; l_v = 16; end
                2: begin hold_v = 3; lmon_v = 0; a_v = 31; b_v = 31; l_v = 31; end
                6: begin hold_v = 76800; a_v = 16; b_v = 16; end
                7: begin knob_v = 10240; hold_v = 131071; a_v = 16; b_v = 16; l_v = 0; end
                default: ;
            endcase
            configure(knob_v, hold_v, lmon_v, a_v, b_v, l_v, noisy);
            gen_phase(75);
            wait_drained();
        end

        // Wait for any stray result before the verdict
        repeat (8) @(posedge i_clk);
        if (clip_expect_q.size() != 0) note_error("predicted results never arrived");
        if (err_count == 0) begin
            $display("PASS poly_clipper_with_clip_indicator");
        end else begin
            $display("FAIL poly_clipper_with_clip_indicator");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $display("FAIL poly_clipper_with_clip_indicator");
        $finish;
    end

endmodule

/* poly_clipper_with_clip_indicator.f */
design/pcci_pkg.sv
design/pcci_clip.sv
design/pcci_state.sv
design/poly_clipper_with_clip_indicator.sv
dv/tb_poly_clipper_with_clip_indicator.sv
